/* design/deq_pkg.sv */
// Shared types and codes for the double-ended queue.
`timescale 1ns / 1ps

package deq_pkg;

	localparam int unsigned VALUE_W = 32;
	localparam int unsigned COUNT_W = 5;

	localparam logic [2:0] CMD_PUSH_BACK  = 3'd0;
	localparam logic [2:0] CMD_PUSH_FRONT = 3'd1;
	localparam logic [2:0] CMD_POP_BACK   = 3'd2;
	localparam logic [2:0] CMD_POP_FRONT  = 3'd3;
	localparam logic [2:0] CMD_QUERY      = 3'd4;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_FULL  = 2'd2
	} deq_status_t;

	typedef struct packed {
		logic [2:0]                command;
		logic signed [VALUE_W-1:0] value;
	} deq_cmd_t;

	typedef struct packed {
		logic [1:0]                status;
		logic signed [VALUE_W-1:0] front_value;
		logic signed [VALUE_W-1:0] back_value;
		logic [COUNT_W-1:0]        count;
		logic                      is_empty;
	} deq_rsp_t;

endpackage

/* design/deq_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module deq_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Read returns the old contents on a same-address write.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

/* design/double_ended_queue_top.sv */
// Double-ended queue of signed 32-bit values held in a RAM ring.
//
// Usage: each transfer on the cmd channel carries a command (push back,
// push front, pop back, pop front, query) and a value. Every command gives
// exactly one transfer on the rsp channel: status (ok, empty on a pop of an
// empty queue, full on a push past DEPTH), the front and back values after
// the command (zero when empty), the entry count and an empty flag.
// Flow: an accepted command first updates the pointers and count and reads
// the two RAM copies at the new front and back pointers; the registered
// read data then loads the response register. A new command is not taken
// until the one in flight has loaded its result. A write and a read of the
// same slot in one cycle are forwarded.
// cmd_stall is high while a command is in flight. A result waiting on
// rsp_stall blocks the next command: its RAM access completes and
// it then holds in the run state until the response register frees up.
// Reset empties the queue (pointers and count to zero); slot contents are
// left as they are and are never shown before written.
`timescale 1ns / 1ps

module double_ended_queue_top #(
	parameter int unsigned DEPTH = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_stall,
	input  deq_pkg::deq_cmd_t cmd,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output deq_pkg::deq_rsp_t rsp
);

	import deq_pkg::*;

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_RUN  = 2'b10
	} state_t;

	state_t state_q;

	logic [AW-1:0] front_q, back_q;
	logic [CW-1:0] count_q;

	logic [AW-1:0] front_nx, back_nx, wr_addr;
	logic [CW-1:0] count_nx;
	logic          wr_en;
	deq_status_t   status_nx;
	logic          accept, load_rsp;

	deq_status_t          status_s1;
	logic [CW-1:0]        count_s1;
	logic                 fwd_front_s1, fwd_back_s1;
	logic [VALUE_W-1:0]   wr_data_s1;
	logic [VALUE_W-1:0]   front_rd, back_rd, front_val, back_val;

	deq_rsp_t rsp_q;
	logic     rsp_valid_q;

	function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] i);
		return (i == LAST_IDX) ? '0 : i + AW'(1);
	endfunction

	function automatic logic [AW-1:0] ring_prev(input logic [AW-1:0] i);
		return (i == '0) ? LAST_IDX : i - AW'(1);
	endfunction

	assign cmd_stall = (state_q == S_RUN);
	assign accept    = cmd_valid && !cmd_stall;
	assign load_rsp  = (state_q == S_RUN) && (!rsp_valid_q || !rsp_stall);

	always_comb begin
		front_nx  = front_q;
		back_nx   = back_q;
		count_nx  = count_q;
		wr_addr   = front_q;
		wr_en     = 1'b0;
		status_nx = STAT_OK;
		case (cmd.command)
			CMD_PUSH_BACK, CMD_PUSH_FRONT: begin
				if (count_q == FULL_CNT) begin
					status_nx = STAT_FULL;
				end else begin
					if (count_q == '0) begin
						back_nx = front_q;
						wr_addr = front_q;
					end else if (cmd.command == CMD_PUSH_BACK) begin
						back_nx = ring_next(back_q);
						wr_addr = back_nx;
					end else begin
						front_nx = ring_prev(front_q);
						wr_addr  = front_nx;
					end
					wr_en    = accept;
					count_nx = count_q + CW'(1);
				end
			end
			CMD_POP_BACK, CMD_POP_FRONT: begin
				if (count_q == '0) begin
					status_nx = STAT_EMPTY;
				end else begin
					if (count_q != CW'(1)) begin
						if (cmd.command == CMD_POP_BACK) begin
							back_nx = ring_prev(back_q);
						end else begin
							front_nx = ring_next(front_q);
						end
					end
					count_nx = count_q - CW'(1);
				end
			end
			CMD_QUERY: begin
				status_nx = STAT_OK;
			end
			default: begin
				status_nx = STAT_OK;
			end
		endcase
	end

	// Two copies of the ring, written alike, read at front and back.
	deq_ram #(.WIDTH(VALUE_W), .DEPTH(DEPTH)) u_front_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (cmd.value),
		.rd_en   (accept),
		.rd_addr (front_nx),
		.rd_data (front_rd)
	);

	deq_ram #(.WIDTH(VALUE_W), .DEPTH(DEPTH)) u_back_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (cmd.value),
		.rd_en   (accept),
		.rd_addr (back_nx),
		.rd_data (back_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			front_q     <= '0;
			back_q      <= '0;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				front_q <= front_nx;
				back_q  <= back_nx;
				count_q <= count_nx;
				state_q <= S_RUN;
			end else if (load_rsp) begin
				state_q <= S_IDLE;
			end
			if (load_rsp) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Hold the in-flight command's side data; forward a same-slot write.
	always_ff @(posedge clk) begin
		if (accept) begin
			status_s1    <= status_nx;
			count_s1     <= count_nx;
			fwd_front_s1 <= wr_en && (wr_addr == front_nx);
			fwd_back_s1  <= wr_en && (wr_addr == back_nx);
			wr_data_s1   <= cmd.value;
		end
	end

	assign front_val = fwd_front_s1 ? wr_data_s1 : front_rd;
	assign back_val  = fwd_back_s1 ? wr_data_s1 : back_rd;

	always_ff @(posedge clk) begin
		if (load_rsp) begin
			rsp_q.status      <= status_s1;
			rsp_q.count       <= COUNT_W'(count_s1);
			rsp_q.is_empty    <= (count_s1 == '0);
			rsp_q.front_value <= (count_s1 == '0) ? '0 : front_val;
			rsp_q.back_value  <= (count_s1 == '0) ? '0 : back_val;
		end
	end

	assign rsp       = rsp_q;
	assign rsp_valid = rsp_valid_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT)
		else $error("entry count above capacity");

	a_single_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == CW'(1)) |-> (front_q == back_q))
		else $error("one entry but front and back pointers differ");

	a_full_no_grow: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && count_q == FULL_CNT &&
			(cmd.command == CMD_PUSH_BACK || cmd.command == CMD_PUSH_FRONT))
		|=> (count_q == FULL_CNT))
		else $error("count moved past or off capacity on a full push");

	a_rsp_from_run: assert property (@(posedge clk) disable iff (!arst_n)
		load_rsp |=> (rsp_valid_q && state_q == S_IDLE))
		else $error("result load did not present a response");

	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_stall && state_q == S_RUN) |=> (state_q == S_RUN))
		else $error("in-flight command left run state while response stalled");

endmodule
